// File: rtl/core/pair_gravity_impulse_unit_macros.svh
// assertion macros used by the port-level checker in pgi_checker.sv
`ifndef PAIR_GRAVITY_IMPULSE_UNIT_MACROS_SVH
`define PAIR_GRAVITY_IMPULSE_UNIT_MACROS_SVH

// next-cycle implication, masked while reset is high
`define PGI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication that also holds across reset
`define PGI_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pgi_pkg.sv
// shared types and constants of the pair gravity impulse unit
package pgi_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int DT_FRAC       = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF   = 2'd1;

  localparam logic ACT_INIT  = 1'b0;
  localparam logic ACT_SOLVE = 1'b1;

  localparam logic OP_DIV  = 1'b0;
  localparam logic OP_SQRT = 1'b1;

  typedef struct packed {
    logic start;
    logic op;
  } div_req_t;

  typedef struct packed {
    logic               action;
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [63:0]        inv_mass_pair;
    logic [15:0]        step_time;
    logic               warm_start;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic signed [31:0] impulse_out_x;
    logic signed [31:0] impulse_out_y;
    logic               settled;
  } out_word_t;

endpackage

// File: rtl/core/pgi_stream_if.sv
// valid/ready stream channel carrying one word of type T
interface pgi_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: rtl/core/pgi_mul.sv
// 64x64 multiplier built from one 32x32 multiplier over four passes
module pgi_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   idx;
  logic         busy;
  logic [63:0]  preg;
  logic [1:0]   psh;
  logic [127:0] acc;
  logic [63:0]  part;
  logic [127:0] addend;

  always_comb begin
    case (idx[1:0])
      2'd0:    part = a_q[31:0] * b_q[31:0];
      2'd1:    part = a_q[31:0] * b_q[63:32];
      2'd2:    part = a_q[63:32] * b_q[31:0];
      default: part = a_q[63:32] * b_q[63:32];
    endcase
  end

  always_comb begin
    case (psh)
      2'd0:    addend = {64'd0, preg};
      2'd3:    addend = {preg, 64'd0};
      default: addend = {32'd0, preg, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      idx  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_q  <= a;
        b_q  <= b;
        acc  <= '0;
        idx  <= 3'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (idx != 3'd4) begin
          preg <= part;
          psh  <= idx[1:0];
        end
        if (idx != 3'd0) acc <= acc + addend;
        if (idx == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        idx <= idx + 3'd1;
      end
    end
  end

  assign prod = acc;

endmodule

// File: rtl/core/pgi_divsqrt.sv
// restoring divider and square root sharing one compare/subtract, one bit per cycle
module pgi_divsqrt #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 66
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pgi_pkg::div_req_t      req,
  input  logic [NUM_W-1:0]       num,
  input  logic [DEN_W-1:0]       den,
  output logic [NUM_W-1:0]       quot,
  output logic                   done
);

  localparam int CMP_W = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 3;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh, qr;
  logic [DEN_W-1:0] rem, den_q;
  logic             op_q, zero_den, busy;
  logic [CNT_W-1:0] cnt;
  logic [CMP_W-1:0] part, trial, diff;
  logic             ge;

  always_comb begin
    if (op_q == pgi_pkg::OP_SQRT) begin
      part  = {{(CMP_W-DEN_W-2){1'b0}}, rem, sh[NUM_W-1 -: 2]};
      trial = {{(CMP_W-NUM_W-2){1'b0}}, qr, 2'b01};
    end else begin
      part  = {{(CMP_W-DEN_W-1){1'b0}}, rem, sh[NUM_W-1]};
      trial = {{(CMP_W-DEN_W){1'b0}}, den_q};
    end
    diff = part - trial;
    ge   = (part >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        op_q     <= req.op;
        sh       <= num;
        den_q    <= den;
        rem      <= '0;
        qr       <= '0;
        zero_den <= (req.op == pgi_pkg::OP_DIV) && (den == '0);
        cnt      <= (req.op == pgi_pkg::OP_SQRT) ? CNT_W'(NUM_W / 2) : CNT_W'(NUM_W);
      end else if (busy) begin
        rem <= ge ? diff[DEN_W-1:0] : part[DEN_W-1:0];
        qr  <= {qr[NUM_W-2:0], ge};
        sh  <= (op_q == pgi_pkg::OP_SQRT) ? (sh << 2) : (sh << 1);
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = zero_den ? '0 : qr;

endmodule

// File: rtl/core/pair_gravity_impulse_unit.sv
// top level: sequencer driving the shared multiplier and divider/square-root unit
//
//  channel  | dir | handshake           | word
//  ---------+-----+---------------------+------------------------------------------
//  cmd      | in  | valid/ready         | pgi_pkg::in_word_t  (action, bodies, dt)
//  res      | out | valid/ready         | pgi_pkg::out_word_t (velocities, impulse)
//  cfg      | in  | cfg_we, no wait     | cfg_index selects strength or cutoff
//
// one word at a time: cmd.ready is high only while the sequencer is idle
// solve word: six 64x64 products, each run on the 32x32 unit
// init word: up to six one-bit-per-cycle divisions and the square root
//   on the shared divider
// a finished word waits in the output register; the next cmd word is taken meanwhile
// synchronous reset clears the impulse and the handshake state and sets strength and cutoff to 65536
module pair_gravity_impulse_unit #(
  parameter int FRAC_BITS = pgi_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pgi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pgi_pkg::CFG_DATA_W-1:0]    cfg_data,
  pgi_stream_if.sink                        cmd,
  pgi_stream_if.source                      res
);

  // numerator holds f << 2F and the 66-bit squared distance for the root
  localparam int NUM_W    = (32 + 2 * FRAC_BITS > 66) ? (32 + 2 * FRAC_BITS) : 66;
  localparam int DEN_W    = 66;
  localparam int MIN_DIST = ((1 << FRAC_BITS) + 50) / 100;
  localparam logic [65:0]  MIN_D2 = 66'(MIN_DIST) * 66'(MIN_DIST);
  localparam logic [127:0] CAP128 = 128'd1 << 62;
  localparam logic [62:0]  CAP63  = 63'd1 << 62;

  typedef enum logic [20:0] {
    S_IDLE     = 21'h000001,
    S_PREP     = 21'h000002,
    S_SQ_X     = 21'h000004,
    S_SQ_Y     = 21'h000008,
    S_SQRT     = 21'h000010,
    S_CUT      = 21'h000020,
    S_R2       = 21'h000040,
    S_TD       = 21'h000080,
    S_TR       = 21'h000100,
    S_MASS     = 21'h000200,
    S_MASS_DIV = 21'h000400,
    S_GM       = 21'h000800,
    S_DIR      = 21'h001000,
    S_DIR_DIV  = 21'h002000,
    S_COMP     = 21'h004000,
    S_WARM     = 21'h008000,
    S_APPLY    = 21'h010000,
    S_PX       = 21'h020000,
    S_PA       = 21'h040000,
    S_PB       = 21'h080000,
    S_OUT      = 21'h100000
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [57:0] v);
    if (v > 58'sd2147483647) return 32'sh7fffffff;
    else if (v < -58'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic [62:0] sat62(input logic [127:0] v);
    return (v > CAP128) ? CAP63 : v[62:0];
  endfunction

  // signed 32-bit value from a magnitude and a sign, saturated
  function automatic logic [31:0] signed_sat(input logic [62:0] m, input logic neg);
    if (neg) return (m >= 63'h80000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
    else return (m >= 63'h7fffffff) ? 32'h7fffffff : m[31:0];
  endfunction

  state_t state;

  // configuration and kept impulse
  logic [31:0]        f_reg, r_reg;
  logic signed [31:0] imp_x, imp_y;

  // word under work
  logic               act, warm;
  logic [32:0]        mdel [2];
  logic               dneg [2];
  logic signed [31:0] va [2];
  logic signed [31:0] vb [2];
  logic [31:0]        inv_a, inv_b;
  logic [15:0]        dt;

  // intermediates
  logic [65:0]        d2;
  logic [32:0]        len;
  logic [63:0]        r2;
  logic [NUM_W-1:0]   td;
  logic [62:0]        g;
  logic [31:0]        pm;
  logic               pneg, mass_sel, ax, changed;

  // output register
  logic               out_valid;
  pgi_pkg::out_word_t out_q;

  // shared units
  logic               mul_start, mul_done;
  logic [63:0]        mul_a, mul_b;
  logic [127:0]       mul_prod, prod_sh;
  pgi_pkg::div_req_t  div_req;
  logic [NUM_W-1:0]   div_num, div_q;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;

  pgi_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod),
    .done (mul_done)
  );

  pgi_divsqrt #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .num (div_num),
    .den (div_den),
    .quot(div_q),
    .done(div_done)
  );

  // combinational helpers
  logic [65:0]        d2_sum;
  logic [NUM_W-1:0]   strength_num;
  logic [31:0]        inv_sel;
  logic signed [31:0] imp_sel;
  logic [31:0]        imp_mag;
  logic signed [57:0] term;
  logic signed [31:0] a_new, b_new;
  logic [32:0]        dx, dy;
  pgi_pkg::in_word_t  w;

  assign w            = cmd.data;
  assign dx           = {w.pos_a_x[31], w.pos_a_x} - {w.pos_b_x[31], w.pos_b_x};
  assign dy           = {w.pos_a_y[31], w.pos_a_y} - {w.pos_b_y[31], w.pos_b_y};
  assign prod_sh      = mul_prod >> FRAC_BITS;
  assign d2_sum       = d2 + mul_prod[65:0];
  assign strength_num = NUM_W'(f_reg) << (2 * FRAC_BITS);
  assign inv_sel      = mass_sel ? inv_b : inv_a;
  assign imp_sel      = ax ? imp_y : imp_x;
  assign imp_mag      = imp_sel[31] ? (~imp_sel + 32'd1) : imp_sel;

  // velocity step: magnitude of (px * inv) >> F, given the sign of px
  always_comb begin
    term  = pneg ? -$signed({2'b00, mul_prod[FRAC_BITS +: 56]})
                 :  $signed({2'b00, mul_prod[FRAC_BITS +: 56]});
    a_new = sat32(58'(va[ax]) - term);
    b_new = sat32(58'(vb[ax]) + term);
  end

  // operand selection for the shared units
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_req   = '0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_PREP: begin
        mul_start = 1'b1;
        mul_a     = 64'(mdel[0]);
        mul_b     = 64'(mdel[0]);
      end
      S_SQ_X: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = 64'(mdel[1]);
          mul_b     = 64'(mdel[1]);
        end
      end
      S_SQ_Y: begin
        if (mul_done && d2_sum != '0) begin
          div_req.start = 1'b1;
          div_req.op    = pgi_pkg::OP_SQRT;
          div_num       = NUM_W'(d2_sum);
        end
      end
      S_CUT: begin
        if (r_reg != '0) begin
          mul_start = 1'b1;
          mul_a     = 64'(r_reg);
          mul_b     = 64'(r_reg);
        end
      end
      S_R2: begin
        if (mul_done) begin
          div_req.start = 1'b1;
          div_req.op    = pgi_pkg::OP_DIV;
          div_num       = strength_num;
          div_den       = d2;
        end
      end
      S_TD: begin
        if (div_done) begin
          div_req.start = 1'b1;
          div_req.op    = pgi_pkg::OP_DIV;
          div_num       = strength_num;
          div_den       = DEN_W'(r2);
        end
      end
      S_MASS: begin
        // zero inverse mass means unit mass
        if (inv_sel == '0) begin
          mul_start = 1'b1;
          mul_a     = 64'(g);
          mul_b     = 64'd1 << FRAC_BITS;
        end else begin
          div_req.start = 1'b1;
          div_req.op    = pgi_pkg::OP_DIV;
          div_num       = NUM_W'(1) << (2 * FRAC_BITS);
          div_den       = DEN_W'(inv_sel);
        end
      end
      S_MASS_DIV, S_DIR_DIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = 64'(g);
          mul_b     = div_q[63:0];
        end
      end
      S_DIR: begin
        if (len != '0) begin
          div_req.start = 1'b1;
          div_req.op    = pgi_pkg::OP_DIV;
          div_num       = NUM_W'(mdel[ax]) << FRAC_BITS;
          div_den       = DEN_W'(len);
        end
      end
      S_APPLY: begin
        mul_start = 1'b1;
        mul_a     = 64'(imp_mag);
        mul_b     = 64'(dt);
      end
      S_PX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = 64'(mul_prod[pgi_pkg::DT_FRAC +: 32]);
          mul_b     = 64'(inv_a);
        end
      end
      S_PA: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = 64'(pm);
          mul_b     = 64'(inv_b);
        end
      end
      default: ;
    endcase
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      imp_x     <= '0;
      imp_y     <= '0;
      f_reg     <= 32'd65536;
      r_reg     <= 32'd65536;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pgi_pkg::REG_STRENGTH: f_reg <= cfg_data;
          pgi_pkg::REG_CUTOFF:   r_reg <= cfg_data;
          default: ;
        endcase
      end

      // the output state reloads the register itself
      if (out_valid && res.ready && state != S_OUT) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act     <= w.action;
            warm    <= w.warm_start;
            mdel[0] <= dx[32] ? (~dx + 33'd1) : dx;
            mdel[1] <= dy[32] ? (~dy + 33'd1) : dy;
            dneg[0] <= dx[32];
            dneg[1] <= dy[32];
            va[0]   <= w.vel_a_x;
            va[1]   <= w.vel_a_y;
            vb[0]   <= w.vel_b_x;
            vb[1]   <= w.vel_b_y;
            inv_a   <= w.inv_mass_pair[63:32];
            inv_b   <= w.inv_mass_pair[31:0];
            dt      <= w.step_time;
            changed <= 1'b0;
            ax      <= 1'b0;
            state   <= (w.action == pgi_pkg::ACT_SOLVE) ? S_APPLY : S_PREP;
          end
        end
        S_PREP: state <= S_SQ_X;
        S_SQ_X: begin
          if (mul_done) begin
            d2    <= mul_prod[65:0];
            state <= S_SQ_Y;
          end
        end
        S_SQ_Y: begin
          if (mul_done) begin
            // coincident bodies: minimum distance, no direction
            if (d2_sum == '0) begin
              d2    <= MIN_D2;
              len   <= '0;
              state <= S_CUT;
            end else begin
              d2    <= d2_sum;
              state <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (div_done) begin
            len   <= div_q[32:0];
            state <= S_CUT;
          end
        end
        S_CUT: begin
          if (r_reg == '0) begin
            g        <= '0;
            mass_sel <= 1'b0;
            state    <= S_MASS;
          end else begin
            state <= S_R2;
          end
        end
        S_R2: begin
          if (mul_done) begin
            r2    <= mul_prod[63:0];
            state <= S_TD;
          end
        end
        S_TD: begin
          if (div_done) begin
            td    <= div_q;
            state <= S_TR;
          end
        end
        S_TR: begin
          if (div_done) begin
            // beyond the cutoff the magnitude clamps to zero
            g        <= (div_q < td) ? sat62(128'(td - div_q)) : '0;
            mass_sel <= 1'b0;
            state    <= S_MASS;
          end
        end
        S_MASS: state <= (inv_sel == '0) ? S_GM : S_MASS_DIV;
        S_MASS_DIV: begin
          if (div_done) state <= S_GM;
        end
        S_GM: begin
          if (mul_done) begin
            g <= sat62(prod_sh);
            if (!mass_sel) begin
              mass_sel <= 1'b1;
              state    <= S_MASS;
            end else begin
              ax    <= 1'b0;
              state <= S_DIR;
            end
          end
        end
        S_DIR: begin
          if (len == '0) begin
            if (ax) imp_y <= '0;
            else imp_x <= '0;
            if (ax) state <= S_WARM;
            else ax <= 1'b1;
          end else begin
            state <= S_DIR_DIV;
          end
        end
        S_DIR_DIV: begin
          if (div_done) state <= S_COMP;
        end
        S_COMP: begin
          if (mul_done) begin
            if (ax) imp_y <= signed_sat(sat62(prod_sh), dneg[1]);
            else imp_x <= signed_sat(sat62(prod_sh), dneg[0]);
            if (ax) begin
              state <= S_WARM;
            end else begin
              ax    <= 1'b1;
              state <= S_DIR;
            end
          end
        end
        S_WARM: begin
          // warm start off: impulse dropped, velocities pass through
          if (!warm) begin
            imp_x <= '0;
            imp_y <= '0;
            state <= S_OUT;
          end else begin
            ax    <= 1'b0;
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          pneg  <= imp_sel[31];
          state <= S_PX;
        end
        S_PX: begin
          if (mul_done) begin
            pm    <= mul_prod[pgi_pkg::DT_FRAC +: 32];
            state <= S_PA;
          end
        end
        S_PA: begin
          if (mul_done) begin
            va[ax]  <= a_new;
            changed <= changed | (a_new != va[ax]);
            state   <= S_PB;
          end
        end
        S_PB: begin
          if (mul_done) begin
            vb[ax]  <= b_new;
            changed <= changed | (b_new != vb[ax]);
            if (ax) begin
              state <= S_OUT;
            end else begin
              ax    <= 1'b1;
              state <= S_APPLY;
            end
          end
        end
        S_OUT: begin
          if (!out_valid || res.ready) begin
            out_q.new_vel_a_x   <= va[0];
            out_q.new_vel_a_y   <= va[1];
            out_q.new_vel_b_x   <= vb[0];
            out_q.new_vel_b_y   <= vb[1];
            out_q.impulse_out_x <= imp_x;
            out_q.impulse_out_y <= imp_y;
            out_q.settled       <= (act == pgi_pkg::ACT_SOLVE) && !changed;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready = (state == S_IDLE);
  assign res.valid = out_valid;
  assign res.data  = out_q;

endmodule

// File: rtl/core/pgi_checker.sv
// port-level checks on the pair gravity impulse unit, bound to the top level
`include "pair_gravity_impulse_unit_macros.svh"

module pgi_checker (
  input logic               clk,
  input logic               rst,
  input logic               cmd_valid,
  input logic               cmd_ready,
  input logic               res_valid,
  input logic               res_ready,
  input pgi_pkg::out_word_t res_data
);

  `PGI_ASSERT_ALWAYS(a_reset_idle, clk, rst, !res_valid && cmd_ready, "reset left a word or busy state")
  `PGI_ASSERT_NEXT(a_busy_after_take, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "took a second word while busy")
  `PGI_ASSERT_NEXT(a_no_instant_word, clk, rst, cmd_valid && cmd_ready, !$rose(res_valid), "result appeared one cycle after input")
  `PGI_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result word changed")

endmodule

bind pair_gravity_impulse_unit pgi_checker u_pgi_checker (
  .clk      (clk),
  .rst      (rst),
  .cmd_valid(cmd.valid),
  .cmd_ready(cmd.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_data (res.data)
);

// File: verif/pair_gravity_impulse_checker.sv
// checker for the pair gravity impulse unit: predicts each result word and compares it
module pair_gravity_impulse_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pgi_pkg::CFG_DATA_W-1:0] cfg_data,
  pgi_stream_if                          cmd,
  pgi_stream_if                          res,
  output int                             errors,
  output int                             outstanding,
  output int                             words_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import pgi_pkg::*;

  typedef logic [127:0] u128_t;
  localparam logic [63:0] CAP62    = 64'h4000_0000_0000_0000;
  localparam logic [63:0] ONE_Q    = 64'd1 << 16;
  localparam logic [63:0] MIN_DIST = ((64'd1 << 16) + 64'd50) / 64'd100;

  logic [31:0]  strength;
  logic [31:0]  cutoff;
  longint       held_imp_x;
  longint       held_imp_y;
  out_word_t    expected_q[$];

  function automatic logic [63:0] cap62(u128_t a);
    return (a > u128_t'(CAP62)) ? CAP62 : a[63:0];
  endfunction

  function automatic logic [63:0] magnitude(longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic longint sat_from_mag(logic [63:0] m, bit neg);
    if (neg) return (m >= 64'h8000_0000) ? -longint'(64'h8000_0000) : -longint'(m);
    return (m >= 64'h7FFF_FFFF) ? longint'(64'h7FFF_FFFF) : longint'(m);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // (v * k) >> s with the magnitude truncated toward zero
  function automatic longint scale_trunc(longint v, logic [63:0] k, int s);
    logic [63:0] m;
    m = (magnitude(v) * k) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic logic [63:0] mass_from_inv(logic [31:0] inv);
    return (inv == 0) ? ONE_Q : (64'd1 << 32) / {32'd0, inv};
  endfunction

  function automatic logic [63:0] int_sqrt(u128_t n);
    logic [63:0] root;
    logic [63:0] trial;
    root = 0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (!(n < u128_t'(trial) * u128_t'(trial))) root = trial;
    end
    return root;
  endfunction

  function automatic longint impulse_axis(longint delta, logic [63:0] len, logic [63:0] g);
    logic [63:0] dir;
    if (len == 0) return 0;
    dir = (magnitude(delta) << 16) / len;
    return sat_from_mag(cap62((u128_t'(g) * u128_t'(dir)) >> 16), delta < 0);
  endfunction

  function automatic out_word_t predict_velocities(in_word_t w);
    out_word_t   o;
    longint      dx, dy, px, py, nax, nay, nbx, nby;
    u128_t       d2, num, td, tr;
    logic [63:0] len, g;
    logic [31:0] inv_a, inv_b;
    bit          apply;
    inv_a = w.inv_mass_pair[63:32];
    inv_b = w.inv_mass_pair[31:0];
    apply = 1'b1;
    if (w.action == ACT_INIT) begin
      dx = longint'(w.pos_a_x) - longint'(w.pos_b_x);
      dy = longint'(w.pos_a_y) - longint'(w.pos_b_y);
      d2 = u128_t'(magnitude(dx)) * u128_t'(magnitude(dx))
         + u128_t'(magnitude(dy)) * u128_t'(magnitude(dy));
      len = 0;
      g = 0;
      // coincident bodies: clamp distance, direction stays zero
      if (d2 == 0) d2 = u128_t'(MIN_DIST) * u128_t'(MIN_DIST);
      else len = int_sqrt(d2);
      if (cutoff != 0) begin
        num = u128_t'(strength) << 32;
        td  = num / d2;
        tr  = num / (u128_t'(cutoff) * u128_t'(cutoff));
        if (tr < td) g = cap62(td - tr);
      end
      g = cap62((u128_t'(g) * u128_t'(mass_from_inv(inv_a))) >> 16);
      g = cap62((u128_t'(g) * u128_t'(mass_from_inv(inv_b))) >> 16);
      held_imp_x = impulse_axis(dx, len, g);
      held_imp_y = impulse_axis(dy, len, g);
      if (!w.warm_start) begin
        held_imp_x = 0;
        held_imp_y = 0;
        apply = 1'b0;
      end
    end
    if (apply) begin
      px  = scale_trunc(held_imp_x, {48'd0, w.step_time}, 16);
      py  = scale_trunc(held_imp_y, {48'd0, w.step_time}, 16);
      nax = sat32(longint'(w.vel_a_x) - scale_trunc(px, {32'd0, inv_a}, 16));
      nay = sat32(longint'(w.vel_a_y) - scale_trunc(py, {32'd0, inv_a}, 16));
      nbx = sat32(longint'(w.vel_b_x) + scale_trunc(px, {32'd0, inv_b}, 16));
      nby = sat32(longint'(w.vel_b_y) + scale_trunc(py, {32'd0, inv_b}, 16));
    end else begin
      nax = w.vel_a_x;
      nay = w.vel_a_y;
      nbx = w.vel_b_x;
      nby = w.vel_b_y;
    end
    o.new_vel_a_x   = nax[31:0];
    o.new_vel_a_y   = nay[31:0];
    o.new_vel_b_x   = nbx[31:0];
    o.new_vel_b_y   = nby[31:0];
    o.impulse_out_x = held_imp_x[31:0];
    o.impulse_out_y = held_imp_y[31:0];
    o.settled = (w.action == ACT_SOLVE) && nax == w.vel_a_x && nay == w.vel_a_y
             && nbx == w.vel_b_x && nby == w.vel_b_y;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("[%0t] result word %0d: %s got %h want %h", $time, words_checked, what, got, want);
  endtask

  task automatic compare_word(out_word_t got, out_word_t want);
    if (got.new_vel_a_x !== want.new_vel_a_x)
      report("new_vel_a_x", got.new_vel_a_x, want.new_vel_a_x);
    if (got.new_vel_a_y !== want.new_vel_a_y)
      report("new_vel_a_y", got.new_vel_a_y, want.new_vel_a_y);
    if (got.new_vel_b_x !== want.new_vel_b_x)
      report("new_vel_b_x", got.new_vel_b_x, want.new_vel_b_x);
    if (got.new_vel_b_y !== want.new_vel_b_y)
      report("new_vel_b_y", got.new_vel_b_y, want.new_vel_b_y);
    if (got.impulse_out_x !== want.impulse_out_x)
      report("impulse_out_x", got.impulse_out_x, want.impulse_out_x);
    if (got.impulse_out_y !== want.impulse_out_y)
      report("impulse_out_y", got.impulse_out_y, want.impulse_out_y);
    if (got.settled !== want.settled)
      report("settled", 32'(got.settled), 32'(want.settled));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      strength   = 32'd65536;
      cutoff     = 32'd65536;
      held_imp_x = 0;
      held_imp_y = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_STRENGTH: strength = cfg_data;
          REG_CUTOFF:   cutoff = cfg_data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) expected_q.push_back(predict_velocities(cmd.data));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", '0, '0);
        end else begin
          compare_word(res.data, expected_q.pop_front());
        end
        words_checked++;
      end
    end
    outstanding = expected_q.size();
  end

endmodule

// File: verif/tb_pair_gravity_impulse_unit.sv
// testbench top of the pair gravity impulse unit: stimulus, config phases and verdict
module tb_pair_gravity_impulse_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import pgi_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int NUM_PHASES   = 6;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    calm;        // no idling on either side while set
  int                    errors, outstanding, words_checked;
  int                    init_words, solve_words;

  pgi_stream_if #(.T(in_word_t))  cmd_if ();
  pgi_stream_if #(.T(out_word_t)) res_if ();

  pair_gravity_impulse_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  pair_gravity_impulse_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd_if),
    .res           (res_if),
    .errors        (errors),
    .outstanding   (outstanding),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure: about a quarter of the cycles stalled unless calm
  always @(posedge clk) begin
    res_if.ready <= !rst && (calm || $urandom_range(99) >= 26);
  end

  // hard stop in case the block hangs
  initial begin
    #80_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // present one command word, with random idle cycles ahead of it
  task automatic send_word(in_word_t w);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 26) gap++;
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= w;
    do @(posedge clk); while (!cmd_if.ready);
    if (w.action == ACT_INIT) init_words++;
    else solve_words++;
  endtask

  // config only while nothing is in flight; both registers in back-to-back cycles
  task automatic write_config(logic [31:0] strength, logic [31:0] cutoff);
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_STRENGTH;
    cfg_data  <= strength;
    @(posedge clk);
    cfg_index <= REG_CUTOFF;
    cfg_data  <= cutoff;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_word_t pair_word(logic act, logic [31:0] ax, logic [31:0] ay,
                                         logic [31:0] bx, logic [31:0] by, logic [31:0] vel,
                                         logic [63:0] inv, logic [15:0] dt, logic warm);
    in_word_t w;
    w.action        = act;
    w.pos_a_x       = ax;
    w.pos_a_y       = ay;
    w.pos_b_x       = bx;
    w.pos_b_y       = by;
    w.vel_a_x       = vel;
    w.vel_a_y       = ~vel;
    w.vel_b_x       = vel;
    w.vel_b_y       = ~vel;
    w.inv_mass_pair = inv;
    w.step_time     = dt;
    w.warm_start    = warm;
    return w;
  endfunction

  function automatic logic [31:0] pick_inv_mass();
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return 32'd65536;
      2:       return $urandom_range(1, 1 << 20);
      default: return $urandom;
    endcase
  endfunction

  function automatic int close_offset();
    int k, off;
    k = $urandom_range(18);
    off = $urandom_range(0, 1 << k);
    return $urandom_range(1) ? -off : off;
  endfunction

  // mostly nearby pairs so the force is nonzero, the rest unconstrained noise
  function automatic in_word_t random_word();
    in_word_t w;
    w.action     = ($urandom_range(99) < 40) ? ACT_INIT : ACT_SOLVE;
    w.step_time  = 16'($urandom);
    w.warm_start = $urandom_range(99) < 85;
    if ($urandom_range(99) < 75) begin
      w.pos_a_x = $signed($urandom) >>> 1;
      w.pos_a_y = $signed($urandom) >>> 1;
      w.pos_b_x = w.pos_a_x + close_offset();
      w.pos_b_y = w.pos_a_y + close_offset();
      w.vel_a_x = $signed($urandom) >>> $urandom_range(31);
      w.vel_a_y = $signed($urandom) >>> $urandom_range(31);
      w.vel_b_x = $signed($urandom) >>> $urandom_range(31);
      w.vel_b_y = $signed($urandom) >>> $urandom_range(31);
      w.inv_mass_pair = {pick_inv_mass(), pick_inv_mass()};
    end else begin
      w.pos_a_x = $urandom;
      w.pos_a_y = $urandom;
      w.pos_b_x = $urandom;
      w.pos_b_y = $urandom;
      w.vel_a_x = $urandom;
      w.vel_a_y = $urandom;
      w.vel_b_x = $urandom;
      w.vel_b_y = $urandom;
      w.inv_mass_pair = {$urandom, $urandom};
    end
    return w;
  endfunction

  initial begin
    logic [31:0] phase_strength[NUM_PHASES];
    logic [31:0] phase_cutoff[NUM_PHASES];
    calm = 1'b0;
    init_words = 0;
    solve_words = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_STRENGTH;
    cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data = '0;
    // phase strength/cutoff: reset, extremes, 0 strength, 0 cutoff, small, moderate
    phase_strength = '{32'd65536, 32'hFFFF_FFFF, 32'd0, $urandom, 32'd1, 32'h0010_0000};
    phase_cutoff   = '{32'd65536, 32'hFFFF_FFFF, 32'd65536, 32'd0, 32'd1, 32'h0004_0000};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words under reset config
    // solve right after reset: nothing stored, velocities untouched, settled
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h1234_5678, 64'h0001_0000_0001_0000,
                        16'hFFFF, 1'b1));
    // coincident bodies give a zero impulse
    send_word(pair_word(ACT_INIT, 32'h0003_0000, 32'hFFFF_0000, 32'h0003_0000, 32'hFFFF_0000,
                        32'h0000_8000, 64'h0, 16'hFFFF, 1'b1));
    // one lsb apart, zero inverse masses mean unit mass
    send_word(pair_word(ACT_INIT, 32'd1, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 64'h0,
                        16'hFFFF, 1'b1));
    // solve with pinned velocities and the largest inverse masses
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        16'hFFFF, 1'b1));
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                        16'hFFFF, 1'b1));
    // zero step time leaves the velocities as they are
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h0101_0101, 64'h0001_0000_0001_0000,
                        16'h0000, 1'b1));
    // widest separation, far beyond the cutoff
    send_word(pair_word(ACT_INIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'hFFFF_FFFF, 64'h0000_0001_0000_0001, 16'hFFFF, 1'b1));
    // half a meter apart on x, then warm start off clears the stored impulse
    send_word(pair_word(ACT_INIT, 32'h0000_8000, 0, 0, 0, 32'd0, 64'h0000_4000_0002_0000,
                        16'h8000, 1'b1));
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h0000_1000, 64'h0000_4000_0002_0000,
                        16'h8000, 1'b1));
    send_word(pair_word(ACT_INIT, 32'h0000_8000, 0, 0, 0, 32'h0000_1000,
                        64'h0000_4000_0002_0000, 16'h8000, 1'b0));
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h0000_1000, 64'h0000_4000_0002_0000,
                        16'hFFFF, 1'b1));
    // negative y only, tiny inverse masses blow the impulse up to saturation
    send_word(pair_word(ACT_INIT, 0, 32'hFFFF_FF00, 0, 0, 32'd0, 64'h0000_0001_0000_0001,
                        16'hFFFF, 1'b1));
    send_word(pair_word(ACT_SOLVE, 0, 0, 0, 0, 32'h8000_0000, 64'hFFFF_FFFF_0000_0000,
                        16'hFFFF, 1'b1));

    // random phases, each under its own config; one long calm stretch in phase 3
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) write_config(phase_strength[p], phase_cutoff[p]);
      for (int i = 0; i < RANDOM_WORDS / NUM_PHASES; i++) begin
        calm = (p == 3) && (i >= 40) && (i < 200);
        send_word(random_word());
      end
    end
    calm = 1'b0;
    cmd_if.valid <= 1'b0;

    // drain, then a little slack for any stray word
    do @(posedge clk); while (outstanding != 0);
    repeat (700) @(posedge clk);

    $display("run covered %0d init and %0d solve words over %0d config settings",
             init_words, solve_words, NUM_PHASES);
    $display("%0d result words compared, %0d mismatches", words_checked, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
